>>> src/ple_pkg.sv
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

    // Fixed field widths of the request and result items.
    localparam int VAL_W   = 32;
    localparam int POS_W   = 8;
    localparam int REQ_W   = 3;
    localparam int IDX_W   = 5;
    localparam int CNTO_W  = 5;
    // Width wide enough to compare a position against any count plus one.
    localparam int CMP_W   = 9;
    // A dump emits at most this many result items.
    localparam int MAX_RESULTS = 16;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_HEAD = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_TAIL = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DEL_POS  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_DUMP     = 3'd6;
    // The remaining code is ignored by the block.
    localparam logic [REQ_W-1:0] REQ_UNUSED   = 3'd7;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_DUMP
    } t_state;

    // What every cell of the chain does in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } t_cell_op;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_request;

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] entry_value;
        logic [IDX_W-1:0]        entry_index;
        logic                    last;
        logic [CNTO_W-1:0]       count;
        logic signed [VAL_W-1:0] tail_value;
    } t_result;

    typedef struct packed {
        t_cell_op         op;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

>>> src/ple_cell.sv
// One storage cell of the list chain, holding the entry at a fixed position.
`timescale 1ns / 1ps

module ple_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                            i_clk,
    input  ple_pkg::t_cell_ctl              i_ctl,
    input  logic [CNT_W-1:0]                i_slot,
    input  logic [CNT_W-1:0]                i_count,
    input  logic [ple_pkg::VAL_W-1:0]       i_left,
    input  logic [ple_pkg::VAL_W-1:0]       i_right,
    input  logic [ple_pkg::VAL_W-1:0]       i_head,
    output logic [ple_pkg::VAL_W-1:0]       o_value,
    output logic                            o_sel,
    output logic                            o_tail
);
    import ple_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;

    // Next value: shift towards the tail on insert, towards the head on delete,
    // or rotate the occupied part of the chain by one place during a dump.
    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            CELL_INS: begin
                if (MY_IDX > i_slot) begin
                    n_value = i_left;
                end else if (MY_IDX == i_slot) begin
                    n_value = i_ctl.value;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= i_slot) begin
                    n_value = i_right;
                end
            end
            CELL_ROT: begin
                if (MY_NEXT < i_count) begin
                    n_value = i_right;
                end else if (MY_NEXT == i_count) begin
                    n_value = i_head;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    // The stored entry needs no reset: only occupied cells are ever read.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // Local position matches for the selection and tail read-out.
    assign o_value = r_value;
    assign o_sel   = (MY_IDX == i_slot);
    assign o_tail  = (MY_NEXT == i_count);

endmodule

>>> src/positional_list_engine_core.sv
// Top level of the positional list engine: request decoder, sequencer and cell chain.
`timescale 1ns / 1ps

// Channel   Direction  Ports                       Handshake
// request   in         start, i_request            taken when start is high and busy is low
// result    out        o_strobe, o_result          valid for one cycle while o_strobe is high
//
// For an insert or delete, the cell chain shifts at the edge that takes
// the item, and the result item is presented in the following cycle.
// During a dump the chain rotates by one place per cycle and the head cell is read
// each time, so the list is back in place after a lap.
// Reset is synchronous and active low; it empties the list and returns to idle.
// The receiver cannot stall; busy stays high until the last result item has gone.

module positional_list_engine_core #(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ple_pkg::t_request i_request,
    output logic              busy,
    output logic              o_strobe,
    output ple_pkg::t_result  o_result
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    t_status           r_status;
    t_status           n_status;
    logic [VAL_W-1:0]  r_value;
    logic [VAL_W-1:0]  n_value;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  n_idx;
    logic [VAL_W-1:0]  r_tail;

    t_cell_ctl         w_ctl;
    logic [CNT_W-1:0]  w_slot;
    logic [VAL_W-1:0]  w_val [CAPACITY];
    logic [CAPACITY-1:0] w_sel;
    logic [CAPACITY-1:0] w_tail_hit;
    logic [VAL_W-1:0]  w_sel_value;
    logic [VAL_W-1:0]  w_tail_value;
    logic [CMP_W-1:0]  w_cnt_ext;
    logic [CMP_W-1:0]  w_pos_ext;
    logic [CMP_W-1:0]  w_idx_ext;
    logic [CMP_W-1:0]  w_dump_lim;
    logic              w_full;
    logic              w_empty;

    // Widened copies for the bound checks.
    assign w_cnt_ext  = CMP_W'(r_count);
    assign w_pos_ext  = CMP_W'(i_request.position);
    assign w_idx_ext  = CMP_W'(r_idx);
    assign w_full     = (w_cnt_ext == CMP_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_dump_lim = (w_cnt_ext > CMP_W'(MAX_RESULTS)) ? CMP_W'(MAX_RESULTS) : w_cnt_ext;

    // Chain slot addressed by the request.
    always_comb begin
        case (i_request.req_type)
            REQ_INS_TAIL: w_slot = r_count;
            REQ_DEL_TAIL: w_slot = CNT_W'(r_count - 1'b1);
            REQ_INS_POS,
            REQ_DEL_POS:  w_slot = CNT_W'(w_pos_ext - 1'b1);
            default:      w_slot = '0;
        endcase
    end

    // The cell chain.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_val[g+1];
        end

        ple_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_slot  (w_slot),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_val[0]),
            .o_value (w_val[g]),
            .o_sel   (w_sel[g]),
            .o_tail  (w_tail_hit[g])
        );
    end

    // One-hot read-out of the addressed entry and of the tail entry.
    always_comb begin
        w_sel_value  = '0;
        w_tail_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_sel_value  = w_sel_value  | (w_val[i] & {VAL_W{w_sel[i]}});
            w_tail_value = w_tail_value | (w_val[i] & {VAL_W{w_tail_hit[i]}});
        end
    end

    // Sequencer: decodes an item, drives the chain and steps through a dump.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_status   = r_status;
        n_value    = r_value;
        n_idx      = r_idx;
        w_ctl.op    = CELL_HOLD;
        w_ctl.value = i_request.value;
        o_strobe   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_request.req_type)
                        REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
                            n_state = S_EMIT;
                            n_value = '0;
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else if ((i_request.req_type == REQ_INS_POS) &&
                                         ((w_pos_ext == '0) ||
                                          (w_pos_ext > w_cnt_ext + 1'b1))) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_status = ST_OK;
                                w_ctl.op = CELL_INS;
                                n_count  = CNT_W'(r_count + 1'b1);
                            end
                        end
                        REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_POS: begin
                            n_state = S_EMIT;
                            n_value = '0;
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else if ((i_request.req_type == REQ_DEL_POS) &&
                                         ((w_pos_ext == '0) ||
                                          (w_pos_ext > w_cnt_ext))) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_status = ST_OK;
                                n_value  = w_sel_value;
                                w_ctl.op = CELL_DEL;
                                n_count  = CNT_W'(r_count - 1'b1);
                            end
                        end
                        REQ_DUMP: begin
                            if (w_empty) begin
                                n_state  = S_EMIT;
                                n_status = ST_EMPTY;
                                n_value  = '0;
                            end else begin
                                n_state = S_DUMP;
                                n_idx   = CNT_W'(1);
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                o_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_DUMP: begin
                w_ctl.op = CELL_ROT;
                o_strobe = (w_idx_ext <= CMP_W'(MAX_RESULTS));
                n_idx    = CNT_W'(r_idx + 1'b1);
                if (r_idx == r_count) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result payload: the head cell during a dump, the stored outcome otherwise.
    always_comb begin
        o_result.count = CNTO_W'(r_count);
        if (r_state == S_DUMP) begin
            o_result.status      = ST_OK;
            o_result.entry_value = w_val[0];
            o_result.entry_index = IDX_W'(r_idx);
            o_result.last        = (w_idx_ext == w_dump_lim);
            o_result.tail_value  = r_tail;
        end else begin
            o_result.status      = r_status;
            o_result.entry_value = r_value;
            o_result.entry_index = '0;
            o_result.last        = 1'b1;
            o_result.tail_value  = w_tail_value;
        end
    end

    assign busy = (r_state != S_IDLE);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Payload registers; the tail is held while the chain rotates in a dump.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_value  <= n_value;
        r_idx    <= n_idx;
        if (r_state == S_IDLE) begin
            r_tail <= w_tail_value;
        end
    end

`ifndef SYNTH
    // The list never holds more entries than there are cells.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt_ext <= CMP_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // The count only changes at the edge that takes an item.
    a_count_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> $stable(r_count))
        else $error("entry count changed while busy");

    // An edit gives exactly one final result item in the next cycle.
    a_edit_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_request.req_type != REQ_DUMP) &&
         (i_request.req_type != REQ_UNUSED))
        |=> (o_strobe && o_result.last && (r_state == S_EMIT)))
        else $error("edit did not produce its result item");

    // The final item of a short dump ends the dump.
    a_dump_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DUMP) && o_strobe && o_result.last &&
         (w_cnt_ext <= CMP_W'(MAX_RESULTS)))
        |=> (r_state == S_IDLE))
        else $error("dump continued after its last item");
`endif

endmodule

>>> dv/tb.sv
// Self-checking testbench for the positional list engine core.
`timescale 1ns / 1ps

module tb;
    import ple_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int RAND_ITEMS  = 400;
    localparam int CYCLE_LIMIT = 200000;
    // Settling wait at the end of the run, well over what a full dump needs.
    localparam int DRAIN_WAIT  = 2 * MAX_RESULTS + 8;
    localparam int REQ_BITS    = $bits(t_request);

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct {
        t_request rq;
        bit       typed;
        t_result  want;
    } t_directed_row;

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     start     = 1'b0;
    t_request i_request = '0;
    logic     busy;
    logic     o_strobe;
    t_result  o_result;

    // Shadow copy of the list, kept in step with every accepted request item.
    logic signed [VAL_W-1:0] list_vals [CAPACITY];
    int unsigned             list_len = 0;
    t_result                 due_results [$];

    t_directed_row directed_rows [$];

    int          fail_count      = 0;
    int          results_checked = 0;
    int          items_sent      = 0;
    int unsigned cycle_count     = 0;
    int unsigned burst_left      = 0;
    bit          filling         = 1'b1;

    positional_list_engine_core #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_request (i_request),
        .busy      (busy),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Build one result item from the list as it stands after the request.
    function automatic t_result shape_result(t_status st, logic signed [VAL_W-1:0] v,
                                             int unsigned idx, logic lst);
        t_result r;
        r.status      = st;
        r.entry_value = v;
        r.entry_index = IDX_W'(idx);
        r.last        = lst;
        r.count       = CNTO_W'(list_len);
        r.tail_value  = (list_len == 0) ? '0 : list_vals[list_len - 1];
        return r;
    endfunction

    // Open a gap at the given 0-based slot and place the value in it.
    function automatic void list_insert(int unsigned slot, logic signed [VAL_W-1:0] v);
        int unsigned i;
        for (i = list_len; i > slot; i--)
            list_vals[i] = list_vals[i - 1];
        list_vals[slot] = v;
        list_len++;
    endfunction

    // Take out the entry at the given 0-based slot and close the gap.
    function automatic logic signed [VAL_W-1:0] list_remove(int unsigned slot);
        logic signed [VAL_W-1:0] v;
        int unsigned             i;
        v = list_vals[slot];
        for (i = slot; i + 1 < list_len; i++)
            list_vals[i] = list_vals[i + 1];
        list_len--;
        return v;
    endfunction

    // Apply one request item to the shadow list and queue the result items it causes.
    function automatic void predict_list_op(t_request rq);
        int unsigned             pos;
        int unsigned             n;
        int unsigned             i;
        logic signed [VAL_W-1:0] v;
        pos = rq.position;
        case (rq.req_type)
            REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
                // A full list is checked before the position.
                if (list_len >= CAPACITY) begin
                    due_results.push_back(shape_result(ST_FULL, '0, 0, 1'b1));
                end else if (rq.req_type == REQ_INS_POS && (pos == 0 || pos > list_len + 1)) begin
                    due_results.push_back(shape_result(ST_BADPOS, '0, 0, 1'b1));
                end else begin
                    if (rq.req_type == REQ_INS_HEAD)
                        list_insert(0, rq.value);
                    else if (rq.req_type == REQ_INS_TAIL)
                        list_insert(list_len, rq.value);
                    else
                        list_insert(pos - 1, rq.value);
                    due_results.push_back(shape_result(ST_OK, '0, 0, 1'b1));
                end
            end
            REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_POS: begin
                // An empty list is checked before the position.
                if (list_len == 0) begin
                    due_results.push_back(shape_result(ST_EMPTY, '0, 0, 1'b1));
                end else if (rq.req_type == REQ_DEL_POS && (pos == 0 || pos > list_len)) begin
                    due_results.push_back(shape_result(ST_BADPOS, '0, 0, 1'b1));
                end else begin
                    if (rq.req_type == REQ_DEL_HEAD)
                        v = list_remove(0);
                    else if (rq.req_type == REQ_DEL_TAIL)
                        v = list_remove(list_len - 1);
                    else
                        v = list_remove(pos - 1);
                    due_results.push_back(shape_result(ST_OK, v, 0, 1'b1));
                end
            end
            REQ_DUMP: begin
                if (list_len == 0) begin
                    due_results.push_back(shape_result(ST_EMPTY, '0, 0, 1'b1));
                end else begin
                    n = (list_len > MAX_RESULTS) ? MAX_RESULTS : list_len;
                    for (i = 0; i < n; i++)
                        due_results.push_back(shape_result(ST_OK, list_vals[i], i + 1,
                                                           (i + 1 == n)));
                end
            end
            default: ;
        endcase
    endfunction

    // Append a row to the directed table; typed rows carry their single result item.
    function automatic void add_row(logic [REQ_W-1:0] code, logic signed [VAL_W-1:0] v,
                                    logic [POS_W-1:0] pos, bit typed, t_status st,
                                    logic signed [VAL_W-1:0] ev, int unsigned idx,
                                    int unsigned cnt, logic signed [VAL_W-1:0] tail);
        t_directed_row row;
        row.rq.req_type       = code;
        row.rq.value          = v;
        row.rq.position       = pos;
        row.typed             = typed;
        row.want.status       = st;
        row.want.entry_value  = ev;
        row.want.entry_index  = IDX_W'(idx);
        row.want.last         = 1'b1;
        row.want.count        = CNTO_W'(cnt);
        row.want.tail_value   = tail;
        directed_rows.push_back(row);
    endfunction

    function automatic logic signed [VAL_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return -1;
            3:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Random request item, biased towards growing or shrinking the list by phase.
    function automatic t_request random_request();
        t_request    rq;
        int unsigned r;
        int unsigned top;
        bit          is_ins;
        r = $urandom_range(0, 99);
        rq.value = random_value();
        if (r < 2) begin
            rq.req_type = REQ_UNUSED;
        end else if (r < 12) begin
            rq.req_type = REQ_DUMP;
        end else begin
            is_ins = filling ? (r < 72) : (r < 32);
            case ($urandom_range(0, 2))
                0:       rq.req_type = is_ins ? REQ_INS_HEAD : REQ_DEL_HEAD;
                1:       rq.req_type = is_ins ? REQ_INS_TAIL : REQ_DEL_TAIL;
                default: rq.req_type = is_ins ? REQ_INS_POS  : REQ_DEL_POS;
            endcase
        end
        // Highest legal position for the request in hand.
        top = (rq.req_type == REQ_INS_POS) ? list_len + 1 : ((list_len == 0) ? 1 : list_len);
        case ($urandom_range(0, 9))
            0:       rq.position = POS_W'($urandom_range(0, 255));
            1:       rq.position = POS_W'(list_len + $urandom_range(0, 2));
            2:       rq.position = '0;
            default: rq.position = POS_W'($urandom_range(1, top));
        endcase
        return rq;
    endfunction

    // Present one request item, hold it until taken, then pace the sender.
    task automatic issue(t_request rq, bit typed, t_result want);
        int unsigned gap;
        start     <= 1'b1;
        i_request <= rq;
        do @(posedge i_clk); while (busy);
        predict_list_op(rq);
        if (typed) begin
            void'(due_results.pop_back());
            due_results.push_back(want);
        end
        items_sent++;
        // Bursts of random length, mostly short, sometimes long and unbroken.
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) begin
                i_request <= t_request'(REQ_BITS'({$urandom, $urandom}));
                @(posedge i_clk);
            end
        end
    endtask

    task automatic compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Check every result item against the oldest one still due.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (due_results.size() == 0) begin
                $display("%0t: result item with none due: expected nothing, got %p",
                         $time, o_result);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                compare_field("status", VAL_W'(want.status), VAL_W'(o_result.status));
                compare_field("entry_value", want.entry_value, o_result.entry_value);
                compare_field("entry_index", VAL_W'(want.entry_index),
                              VAL_W'(o_result.entry_index));
                compare_field("last", VAL_W'(want.last), VAL_W'(o_result.last));
                compare_field("count", VAL_W'(want.count), VAL_W'(o_result.count));
                compare_field("tail_value",  want.tail_value,  o_result.tail_value);
                results_checked++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_result     none;
        int unsigned random_done;
        none        = '0;
        random_done = 0;

        // Empty list: every delete and the dump report empty, bad insert positions.
        add_row(REQ_DEL_HEAD, 0, 0, 1, ST_EMPTY, 0, 0, 0, 0);
        add_row(REQ_DEL_TAIL, 32'h1234_5678, 0, 1, ST_EMPTY, 0, 0, 0, 0);
        add_row(REQ_DEL_POS, 0, 1, 1, ST_EMPTY, 0, 0, 0, 0);
        add_row(REQ_DUMP, 0, 0, 1, ST_EMPTY, 0, 0, 0, 0);
        add_row(REQ_INS_POS, 7, 0, 1, ST_BADPOS, 0, 0, 0, 0);
        add_row(REQ_INS_POS, 7, 2, 1, ST_BADPOS, 0, 0, 0, 0);
        // Build up with extreme values; position count+1 appends at the tail.
        add_row(REQ_INS_POS, VAL_MAX, 1, 1, ST_OK, 0, 0, 1, VAL_MAX);
        add_row(REQ_INS_HEAD, VAL_MIN, 0, 1, ST_OK, 0, 0, 2, VAL_MAX);
        add_row(REQ_INS_TAIL, -1, 8'hff, 1, ST_OK, 0, 0, 3, -1);
        add_row(REQ_INS_POS, 5, 4, 1, ST_OK, 0, 0, 4, 5);
        add_row(REQ_INS_POS, 9, 8'hff, 1, ST_BADPOS, 0, 0, 4, 5);
        add_row(REQ_DEL_POS, 0, 0, 1, ST_BADPOS, 0, 0, 4, 5);
        add_row(REQ_DEL_POS, 0, 5, 1, ST_BADPOS, 0, 0, 4, 5);
        add_row(REQ_DUMP, 0, 0, 0, ST_OK, 0, 0, 0, 0);
        add_row(REQ_DEL_POS, 0, 2, 0, ST_OK, 0, 0, 0, 0);
        add_row(REQ_UNUSED, 32'hdead_beef, 1, 0, ST_OK, 0, 0, 0, 0);
        add_row(REQ_DEL_TAIL, 0, 0, 0, ST_OK, 0, 0, 0, 0);
        add_row(REQ_DEL_HEAD, 0, 0, 0, ST_OK, 0, 0, 0, 0);
        // Down to a single entry: dump it, then delete it so the tail clears.
        add_row(REQ_DUMP, 0, 0, 1, ST_OK, -1, 1, 1, -1);
        add_row(REQ_DEL_HEAD, 0, 0, 1, ST_OK, -1, 0, 0, 0);
        add_row(REQ_INS_TAIL, 42, 0, 0, ST_OK, 0, 0, 0, 0);
        add_row(REQ_DEL_POS, 0, 1, 1, ST_OK, 42, 0, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            issue(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].want);

        // Random part: alternate filling to capacity and draining to empty.
        while (random_done < RAND_ITEMS) begin
            t_request rq;
            rq = random_request();
            issue(rq, 1'b0, none);
            if (rq.req_type != REQ_UNUSED)
                random_done++;
            if (filling && list_len == CAPACITY && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && list_len == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;
        end

        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d request items (%0d directed, %0d random) over fill and drain phases,",
                 items_sent, directed_rows.size(), items_sent - directed_rows.size());
        $display("and checked %0d result items field by field.", results_checked);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
